// ===== src/voxel_ray_traversal_top_assert.svh =====
// Assertion macros shared by the voxel ray traversal design.
`ifndef VOXEL_RAY_TRAVERSAL_TOP_ASSERT_SVH
`define VOXEL_RAY_TRAVERSAL_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define VRT_ASSERT_NOW(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, checked on clk and disabled during rst.
`define VRT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== src/vrt_pkg.sv =====
// Shared types, constants and codes of the voxel ray traversal block.
`timescale 1ns / 1ps
package vrt_pkg;

  localparam int GRID_DIM_DEF = 32;
  localparam int POS_W        = 12;
  localparam int T_W          = 32;
  localparam int MAG_W        = 16;
  localparam int DIVQ_W       = 31;
  localparam int CFG_W        = 8;
  localparam int CFG_IDX_W    = 1;
  localparam int NUM_DIV_OPS  = 6;

  localparam logic [CFG_W-1:0] MAX_DIST_RST = 8'd100;
  localparam logic [CFG_W-1:0] INTERACT_RST = 8'd100;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERACT = 1'b1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  localparam logic [1:0] EDIT_NONE    = 2'd0;
  localparam logic [1:0] EDIT_PLACED  = 2'd1;
  localparam logic [1:0] EDIT_REMOVED = 2'd2;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    logic               kind;
    logic [12:0]        origin_x;
    logic [12:0]        origin_y;
    logic [12:0]        origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               place_mode;
    logic               button;
    logic [7:0]         cell_value;
  } vrt_req_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] hit_x;
    logic [4:0] hit_y;
    logic [5:0] hit_z;
    logic [1:0] edit_done;
  } vrt_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic write_item;
    logic div_start;
    logic div_store;
    logic step_check;
    logic step_advance;
    logic read_prev;
    logic res_hit;
    logic edit_remove;
    logic edit_place;
    logic out_load;
  } vrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic is_write;
    logic div_done;
    logic op_last;
    logic limit_reached;
    logic cell_nonzero;
    logic edit_ok;
    logic place_mode;
    logic prev_empty;
  } vrt_sts_t;

endpackage

// ===== src/vrt_stream_if.sv =====
// Valid/ready stream channel carrying one item of a given payload type.
`timescale 1ns / 1ps
interface vrt_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/vrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module vrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/vrt_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module vrt_div import vrt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVQ_W-1:0] dividend,
  input  logic [MAG_W-1:0]  divisor,
  output logic              done,
  output logic [DIVQ_W-1:0] quotient
);
  localparam int CNT_W = $clog2(DIVQ_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [MAG_W-1:0] rem;
  logic [MAG_W:0]   trial;
  logic             fits;

  assign trial = {rem, quotient[DIVQ_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVQ_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[DIVQ_W-2:0], fits};
      rem      <= fits ? MAG_W'(trial - {1'b0, divisor}) : trial[MAG_W-1:0];
    end
  end
endmodule

// ===== src/vrt_datapath.sv =====
// Datapath: grid memory, DDA registers, shared divider and result registers.
`timescale 1ns / 1ps
module vrt_datapath import vrt_pkg::*; #(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vrt_cmd_t             cmd,
  output vrt_sts_t             sts,
  input  vrt_req_t             item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output vrt_rsp_t             out_data
);
  localparam int CW    = $clog2(GRID_DIM);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam pos_t DIM_S = POS_W'(GRID_DIM);

  logic [CFG_W-1:0] max_dist;
  logic [CFG_W-1:0] interact;
  vrt_req_t         cur;
  pos_t             pos [3];
  pos_t             prev [3];
  logic [T_W-1:0]   tmax [3];
  logic [T_W-1:0]   tdelta [3];
  logic [T_W-1:0]   traveled;
  logic [1:0]       sel;
  logic [2:0]       op;
  logic [AW-1:0]    clr_cnt;
  vrt_rsp_t         res;

  logic [12:0]        org [3];
  logic [12:0]        in_org [3];
  logic signed [15:0] dir [3];

  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [7:0]        wdata;
  logic [7:0]        rdata;

  logic [1:0]        op_axis;
  logic [8:0]        num;
  logic [DIVQ_W-1:0] dividend;
  logic [MAG_W-1:0]  mag;
  logic              div_done;
  logic [DIVQ_W-1:0] quotient;
  logic [T_W-1:0]    qval;
  logic [T_W:0]      sum;
  logic [T_W-1:0]    tmax_inc;
  pos_t              pos_x1;
  pos_t              pos_z1;

  function automatic logic in_grid(pos_t p);
    in_grid = !p[POS_W-1] && (p < DIM_S);
  endfunction

  function automatic logic [AW-1:0] cell_addr(pos_t x, pos_t y, pos_t z);
    cell_addr = {z[CW-1:0], y[CW-1:0], x[CW-1:0]};
  endfunction

  assign org[0] = cur.origin_x;
  assign org[1] = cur.origin_y;
  assign org[2] = cur.origin_z;
  assign dir[0] = cur.dir_x;
  assign dir[1] = cur.dir_y;
  assign dir[2] = cur.dir_z;
  assign in_org[0] = item.origin_x;
  assign in_org[1] = item.origin_y;
  assign in_org[2] = item.origin_z;

  // Division operands: even ops give the first boundary time, odd ops the cell pitch.
  assign op_axis  = op[2:1];
  assign num      = dir[op_axis][15] ? {1'b0, org[op_axis][7:0]}
                                     : 9'd256 - {1'b0, org[op_axis][7:0]};
  assign dividend = op[0] ? {1'b1, 30'd0} : {num, 22'd0};
  assign mag      = dir[op_axis][15] ? MAG_W'(-dir[op_axis]) : MAG_W'(dir[op_axis]);
  assign qval     = (dir[op_axis] == 16'sd0) ? '1 : {1'b0, quotient};

  vrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (mag),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sum      = {1'b0, tmax[sel]} + {1'b0, tdelta[sel]};
  assign tmax_inc = sum[T_W] ? '1 : sum[T_W-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = cell_addr(pos[0], pos[1], pos[2]);
    wdata = 8'd0;
    if (cmd.clr_step) begin
      we    = 1'b1;
      waddr = clr_cnt;
    end else if (cmd.write_item) begin
      we    = in_grid(pos[0]) && in_grid(pos[1]) && in_grid(pos[2]);
      wdata = cur.cell_value;
    end else if (cmd.edit_remove) begin
      we    = 1'b1;
    end else if (cmd.edit_place) begin
      we    = 1'b1;
      waddr = cell_addr(prev[0], prev[1], prev[2]);
      wdata = 8'd1;
    end
  end

  assign raddr = cmd.read_prev ? cell_addr(prev[0], prev[1], prev[2])
                               : cell_addr(pos[0], pos[1], pos[2]);

  vrt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist <= MAX_DIST_RST;
      interact <= INTERACT_RST;
      clr_cnt  <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_MAX_DIST) begin
        max_dist <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_INTERACT) begin
        interact <= cfg_wdata;
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  assign pos_x1 = pos[0] + pos_t'(1);
  assign pos_z1 = pos[2] + pos_t'(1);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cur      <= item;
      traveled <= '0;
      op       <= '0;
      res      <= '0;
      for (int i = 0; i < 3; i++) begin
        pos[i]  <= POS_W'(in_org[i][12:8]);
        prev[i] <= POS_W'(in_org[i][12:8]);
      end
    end
    if (cmd.div_store) begin
      if (op[0]) begin
        tdelta[op_axis] <= qval;
      end else begin
        tmax[op_axis] <= qval;
      end
      op <= op + 1'b1;
    end
    if (cmd.step_check) begin
      if (tmax[0] < tmax[1]) begin
        sel <= (tmax[0] < tmax[2]) ? 2'd0 : 2'd2;
      end else begin
        sel <= (tmax[1] < tmax[2]) ? 2'd1 : 2'd2;
      end
    end
    if (cmd.step_advance) begin
      for (int i = 0; i < 3; i++) begin
        prev[i] <= pos[i];
      end
      if (dir[sel][15]) begin
        pos[sel] <= pos[sel] - pos_t'(1);
      end else if (dir[sel] != 16'sd0) begin
        pos[sel] <= pos[sel] + pos_t'(1);
      end
      traveled  <= tmax[sel];
      tmax[sel] <= tmax_inc;
    end
    if (cmd.res_hit) begin
      res.hit   <= 1'b1;
      res.hit_x <= pos_x1[5:0];
      res.hit_y <= pos[1][4:0];
      res.hit_z <= pos_z1[5:0];
    end
    if (cmd.edit_remove) begin
      res.edit_done <= EDIT_REMOVED;
    end
    if (cmd.edit_place) begin
      res.edit_done <= EDIT_PLACED;
    end
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  assign sts.clear_last    = &clr_cnt;
  assign sts.is_write      = cur.kind == KIND_WRITE;
  assign sts.div_done      = div_done;
  assign sts.op_last       = op == 3'(NUM_DIV_OPS - 1);
  assign sts.limit_reached = traveled[T_W-1:16] >= {8'd0, max_dist};
  assign sts.cell_nonzero  = in_grid(pos[0]) && in_grid(pos[1]) && in_grid(pos[2])
                             && (rdata != 8'd0);
  assign sts.edit_ok       = cur.button && ((traveled[T_W-1:16] < {8'd0, interact})
                             || (traveled[T_W-1:16] == {8'd0, interact}
                                 && traveled[15:0] == 16'd0));
  assign sts.place_mode    = cur.place_mode;
  assign sts.prev_empty    = in_grid(prev[0]) && in_grid(prev[1]) && in_grid(prev[2])
                             && (rdata == 8'd0);
endmodule

// ===== src/vrt_ctrl.sv =====
// Controller: sequences clearing, writes, divider setup, the DDA walk and edits.
`timescale 1ns / 1ps
module vrt_ctrl import vrt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  vrt_sts_t sts,
  output vrt_cmd_t cmd
);
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SORT     = 4'd2;
  localparam logic [3:0] S_DIV_GO   = 4'd3;
  localparam logic [3:0] S_DIV_WAIT = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_READ     = 4'd6;
  localparam logic [3:0] S_PREV_RD  = 4'd7;
  localparam logic [3:0] S_PREV_CHK = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_SORT;
        end
      end
      S_SORT: begin
        if (sts.is_write) begin
          cmd.write_item = 1'b1;
          state_next     = S_DONE;
        end else begin
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.div_store = 1'b1;
          state_next    = sts.op_last ? S_CHECK : S_DIV_GO;
        end
      end
      S_CHECK: begin
        if (sts.limit_reached) begin
          state_next = S_DONE;
        end else begin
          cmd.step_check = 1'b1;
          state_next     = S_READ;
        end
      end
      S_READ: begin
        if (sts.cell_nonzero) begin
          cmd.res_hit = 1'b1;
          state_next  = S_DONE;
          if (sts.edit_ok) begin
            if (sts.place_mode) begin
              state_next = S_PREV_RD;
            end else begin
              cmd.edit_remove = 1'b1;
            end
          end
        end else begin
          cmd.step_advance = 1'b1;
          state_next       = S_CHECK;
        end
      end
      S_PREV_RD: begin
        cmd.read_prev = 1'b1;
        state_next    = S_PREV_CHK;
      end
      S_PREV_CHK: begin
        if (sts.prev_empty) begin
          cmd.edit_place = 1'b1;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// ===== src/voxel_ray_traversal_top.sv =====
// Voxel ray traversal block. After reset the grid is cleared one cell per cycle,
// all 2^(3*clog2(GRID_DIM)) cells (32768 at the default size), and no item is taken
// until that pass ends; configuration writes are taken throughout. Items are handled
// one at a time. A write item is accepted, written to the grid and then loaded as its
// result. A cast item first runs six divisions on one shared bit-serial divider, then
// reads the grid once per visited cell and may end in an edit; the walk length sets
// the total. The next item is accepted while the previous result still waits in the
// output register.
`include "voxel_ray_traversal_top_assert.svh"
`timescale 1ns / 1ps
module voxel_ray_traversal_top import vrt_pkg::*; #(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  vrt_stream_if.sink           req,
  vrt_stream_if.source         rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);
  vrt_cmd_t cmd;
  vrt_sts_t sts;
  vrt_rsp_t out_data;

  vrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vrt_datapath #(.GRID_DIM(GRID_DIM)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .item      (req.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

  assign rsp.data = out_data;

  `VRT_ASSERT_NOW(a_no_item_while_clearing, cmd.clr_step, !req.ready, "item taken while clearing")
  `VRT_ASSERT_NOW(a_load_into_free_slot, cmd.out_load, !rsp.valid || rsp.ready, "result overwritten")
  `VRT_ASSERT_NOW(a_one_grid_writer, 1'b1, $onehot0({cmd.clr_step, cmd.write_item, cmd.edit_remove, cmd.edit_place}), "two grid writes at once")
  `VRT_ASSERT_NEXT(a_one_item_at_a_time, req.valid && req.ready, !req.ready, "second item taken too early")
endmodule
